>>> hw/rtl/ppcf_pkg.sv
// Shared constants, codes and types for the planar penalty contact force block.
`default_nettype none

package ppcf_pkg;

	// Default coordinate width (signed Q16.16 at 32 bits)
	localparam int COORD_WIDTH_DEF = 32;

	// Fixed field widths
	localparam int GROUP_W    = 32;
	localparam int DAMAGE_W   = 17;
	localparam int STIFF_W    = 16;
	localparam int SHEAR_W    = 32;
	localparam int KG_W       = STIFF_W + SHEAR_W;
	localparam int KGW_W      = 64;
	localparam int FORCE_W    = 48;
	localparam int OUTCOME_W  = 3;
	localparam int DEN_SHIFT  = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Multiplier slice width and queue depth (power of two)
	localparam int MUL_CHUNK = 16;
	localparam int Q_DEPTH   = 4;

	// Damage of one, Q1.16
	localparam logic [DAMAGE_W-1:0] W_ONE = 17'h10000;

	// Force limits, signed Q32.16
	localparam logic [FORCE_W-1:0] F_MAX     = 48'h7FFF_FFFF_FFFF;
	localparam logic [FORCE_W-1:0] F_MIN_MAG = 48'h8000_0000_0000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHEAR     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP     = 2'd2;

	// Result codes, also used as the item class inside the pipeline
	typedef enum logic [OUTCOME_W-1:0] {
		OUT_SKIP    = 3'd0,
		OUT_NOCONT  = 3'd1,
		OUT_APPLIED = 3'd2,
		OUT_ZERO    = 3'd3,
		OUT_SAT     = 3'd4
	} outcome_t;

endpackage

`default_nettype wire

>>> hw/rtl/ppcf_mulpipe.sv
// Pipelined unsigned multiplier lanes: one 16-bit slice of B per stage, shared sideband.
`default_nettype none

module ppcf_mulpipe #(
	parameter int LANES = 1,
	parameter int AW    = 16,
	parameter int BW    = 17,
	parameter int SW    = 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    vld_i,
	input  wire logic [LANES*AW-1:0]     a_i,
	input  wire logic [LANES*BW-1:0]     b_i,
	input  wire logic [SW-1:0]           side_i,
	output logic                         vld_o,
	output logic [LANES*(AW+BW)-1:0]     p_o,
	output logic [SW-1:0]                side_o
);

	localparam int CH  = ppcf_pkg::MUL_CHUNK;
	localparam int NST = (BW + CH - 1) / CH;
	localparam int BPW = NST * CH;
	localparam int PW  = AW + BW;

	logic [LANES*BPW-1:0] b0;
	logic                 vld_st  [1:NST];
	logic [LANES*AW-1:0]  a_st    [1:NST];
	logic [LANES*BPW-1:0] b_st    [1:NST];
	logic [LANES*PW-1:0]  p_st    [1:NST];
	logic [SW-1:0]        side_st [1:NST];

	// Pad each B lane to whole slices
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			b0[j*BPW +: BPW] = BPW'(b_i[j*BW +: BW]);
		end
	end

	genvar k;
	for (k = 0; k < NST; k++) begin : g_st
		logic                 c_vld;
		logic [LANES*AW-1:0]  c_a;
		logic [LANES*BPW-1:0] c_b;
		logic [LANES*PW-1:0]  c_p;
		logic [SW-1:0]        c_side;

		if (k == 0) begin : g_src0
			assign c_vld  = vld_i;
			assign c_a    = a_i;
			assign c_b    = b0;
			assign c_p    = '0;
			assign c_side = side_i;
		end else begin : g_srcn
			assign c_vld  = vld_st[k];
			assign c_a    = a_st[k];
			assign c_b    = b_st[k];
			assign c_p    = p_st[k];
			assign c_side = side_st[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_st[k+1] <= 1'b0;
			end else if (en) begin
				vld_st[k+1] <= c_vld;
			end
		end

		// Accumulate A times slice k of B
		always_ff @(posedge clk) begin
			if (en) begin
				a_st[k+1]    <= c_a;
				b_st[k+1]    <= c_b;
				side_st[k+1] <= c_side;
				for (int j = 0; j < LANES; j++) begin
					p_st[k+1][j*PW +: PW] <= c_p[j*PW +: PW] +
						((PW'(c_a[j*AW +: AW]) * PW'(c_b[j*BPW + k*CH +: CH])) << (k*CH));
				end
			end
		end
	end

	assign vld_o  = vld_st[NST];
	assign p_o    = p_st[NST];
	assign side_o = side_st[NST];

endmodule

`default_nettype wire

>>> hw/rtl/ppcf_divpipe.sv
// Pipelined restoring divider lanes: overflow check, then one quotient bit per stage.
`default_nettype none

module ppcf_divpipe #(
	parameter int LANES = 3,
	parameter int NW    = 161,
	parameter int DW    = 88,
	parameter int QB    = 48,
	parameter int SW    = 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                vld_i,
	input  wire logic [LANES*NW-1:0] num_i,
	input  wire logic [DW-1:0]       den_i,
	input  wire logic [SW-1:0]       side_i,
	output logic                     vld_o,
	output logic [LANES*QB-1:0]      q_o,
	output logic [LANES-1:0]         big_o,
	output logic [SW-1:0]            side_o
);

	localparam int HW = NW - QB;

	logic [LANES-1:0]    big0;
	logic                vld_st  [0:QB];
	logic [LANES*DW-1:0] rem_st  [0:QB];
	logic [LANES*QB-1:0] lo_st   [0:QB];
	logic [LANES-1:0]    big_st  [0:QB];
	logic [DW-1:0]       den_st  [0:QB];
	logic [SW-1:0]       side_st [0:QB];

	// Quotient needs more than QB bits when the high part reaches the divisor
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			big0[j] = num_i[j*NW + QB +: HW] >= HW'(den_i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_st[0] <= 1'b0;
		end else if (en) begin
			vld_st[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < LANES; j++) begin
				rem_st[0][j*DW +: DW] <= DW'(num_i[j*NW + QB +: HW]);
				lo_st[0][j*QB +: QB]  <= num_i[j*NW +: QB];
			end
			big_st[0]  <= big0;
			den_st[0]  <= den_i;
			side_st[0] <= side_i;
		end
	end

	genvar k, l;
	for (k = 0; k < QB; k++) begin : g_st
		logic [LANES-1:0]    ge;
		logic [LANES*DW-1:0] nrem;
		logic [LANES*QB-1:0] nlo;

		for (l = 0; l < LANES; l++) begin : g_lane
			logic [DW:0] trial;
			logic [DW:0] diff;
			assign trial = {rem_st[k][l*DW +: DW], lo_st[k][l*QB + QB - 1]};
			assign diff  = trial - {1'b0, den_st[k]};
			assign ge[l] = trial >= {1'b0, den_st[k]};
			assign nrem[l*DW +: DW] = ge[l] ? diff[DW-1:0] : trial[DW-1:0];
			assign nlo[l*QB +: QB]  = {lo_st[k][l*QB +: QB-1], ge[l]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_st[k+1] <= 1'b0;
			end else if (en) begin
				vld_st[k+1] <= vld_st[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[k+1]  <= nrem;
				lo_st[k+1]   <= nlo;
				big_st[k+1]  <= big_st[k];
				den_st[k+1]  <= den_st[k];
				side_st[k+1] <= side_st[k];
			end
		end
	end

	assign vld_o  = vld_st[QB];
	assign q_o    = lo_st[QB];
	assign big_o  = big_st[QB];
	assign side_o = side_st[QB];

endmodule

`default_nettype wire

>>> hw/rtl/ppcf_queue.sv
// Small flip-flop queue between the front and back parts.
`default_nettype none

module ppcf_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              not_empty,
	output logic [W-1:0]      pop_data
);

	localparam int DEPTH = ppcf_pkg::Q_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full      = cnt_q == (PTR_W+1)'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ppcf_front.sv
// Front part: accepts a particle, classifies it, forms s - x and the undamaged weight.
`default_nettype none

module ppcf_front #(
	parameter int CW = ppcf_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [ppcf_pkg::GROUP_W-1:0]   particle_groups,
	input  wire logic                           has_mass,
	input  wire logic [CW-1:0]                  pos_x,
	input  wire logic [CW-1:0]                  pos_y,
	input  wire logic [CW-1:0]                  pos_z,
	input  wire logic [CW-1:0]                  surf_x,
	input  wire logic [CW-1:0]                  surf_y,
	input  wire logic [CW-1:0]                  surf_z,
	input  wire logic [CW-1:0]                  norm_x,
	input  wire logic [CW-1:0]                  norm_y,
	input  wire logic [CW-1:0]                  norm_z,
	input  wire logic [ppcf_pkg::DAMAGE_W-1:0]  damage_level,
	input  wire logic [ppcf_pkg::GROUP_W-1:0]   group_select,
	input  wire logic                           q_full,
	output logic                                q_push,
	output logic [6*CW+3+ppcf_pkg::DAMAGE_W+ppcf_pkg::OUTCOME_W-1:0] q_data
);

	localparam int QW = 6*CW + 3 + ppcf_pkg::DAMAGE_W + ppcf_pkg::OUTCOME_W;

	logic                          accept;
	logic                          skip;
	logic                          zero_n;
	logic [CW:0]                   dx;
	logic [CW:0]                   dy;
	logic [CW:0]                   dz;
	logic [ppcf_pkg::DAMAGE_W-1:0] w;
	ppcf_pkg::outcome_t            cls;
	logic                          f_vld_s1;
	logic [QW-1:0]                 f_data_s1;

	assign accept   = in_valid && !in_stall;
	assign in_stall = f_vld_s1 && q_full;
	assign q_push   = f_vld_s1 && !q_full;
	assign q_data   = f_data_s1;

	// Classification
	assign skip   = !has_mass || ((particle_groups & group_select) == '0);
	assign zero_n = (norm_x == '0) && (norm_y == '0) && (norm_z == '0);
	always_comb begin
		if (skip) begin
			cls = ppcf_pkg::OUT_SKIP;
		end else if (zero_n) begin
			cls = ppcf_pkg::OUT_ZERO;
		end else begin
			cls = ppcf_pkg::OUT_APPLIED;
		end
	end

	// Offset from particle to surface point, and undamaged weight
	assign dx = {surf_x[CW-1], surf_x} - {pos_x[CW-1], pos_x};
	assign dy = {surf_y[CW-1], surf_y} - {pos_y[CW-1], pos_y};
	assign dz = {surf_z[CW-1], surf_z} - {pos_z[CW-1], pos_z};
	assign w  = (damage_level > ppcf_pkg::W_ONE) ? '0 : ppcf_pkg::W_ONE - damage_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_vld_s1 <= 1'b0;
		end else if (accept) begin
			f_vld_s1 <= 1'b1;
		end else if (q_push) begin
			f_vld_s1 <= 1'b0;
		end
	end

	// Item layout: class, weight, d z/y/x, n z/y/x
	always_ff @(posedge clk) begin
		if (accept) begin
			f_data_s1 <= {cls, w, dz, dy, dx, norm_z, norm_y, norm_x};
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ppcf_back.sv
// Back part: dot products, force scaling, division by |n|^2 and saturation.
`default_nettype none

module ppcf_back #(
	parameter int CW = ppcf_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_vld,
	input  wire logic [6*CW+3+ppcf_pkg::DAMAGE_W+ppcf_pkg::OUTCOME_W-1:0] q_data,
	output logic                                 q_pop,
	input  wire logic [ppcf_pkg::KG_W-1:0]       kg,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [ppcf_pkg::FORCE_W-1:0]         force_x,
	output logic [ppcf_pkg::FORCE_W-1:0]         force_y,
	output logic [ppcf_pkg::FORCE_W-1:0]         force_z,
	output logic [ppcf_pkg::OUTCOME_W-1:0]       outcome
);

	localparam int OW   = ppcf_pkg::OUTCOME_W;
	localparam int DMW  = ppcf_pkg::DAMAGE_W;
	localparam int FW   = ppcf_pkg::FORCE_W;
	localparam int QW   = 6*CW + 3 + DMW + OW;
	localparam int DOFF = 3*CW;
	localparam int WOFF = DOFF + 3*(CW+1);
	localparam int COFF = WOFF + DMW;
	localparam int P1W  = 2*CW + 1;
	localparam int DOTW = 2*CW + 2;
	localparam int DOTM = 2*CW + 1;
	localparam int N2W  = 2*CW;
	localparam int KGWW = ppcf_pkg::KGW_W;
	localparam int KDW  = KGWW + DOTM;
	localparam int TW   = CW + KDW;
	localparam int DENW = N2W + ppcf_pkg::DEN_SHIFT;
	localparam int SW1  = OW + DMW + 3*CW + 6;
	localparam int SW2  = OW + N2W + 3*CW + 3;
	localparam int SW3  = OW + N2W + 3;
	localparam int SW4  = OW + 3;

	logic en;

	// Whole back pipeline advances unless the result register is held
	assign en    = !out_valid || !out_stall;
	assign q_pop = q_vld && en;

	// Stage 1: take the item off the queue
	logic          v_s1;
	logic [QW-1:0] data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= q_data;
		end
	end

	// Magnitudes and signs of n and d
	logic [3*CW-1:0]     nm;
	logic [3*(CW+1)-1:0] dm;
	logic [2:0]          sn;
	logic [2:0]          sp;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sn[i] = data_s1[i*CW + CW - 1];
			sp[i] = data_s1[i*CW + CW - 1] ^ data_s1[DOFF + i*(CW+1) + CW];
			nm[i*CW +: CW] = sn[i] ? (~data_s1[i*CW +: CW] + 1'b1) : data_s1[i*CW +: CW];
			dm[i*(CW+1) +: CW+1] = data_s1[DOFF + i*(CW+1) + CW] ?
				(~data_s1[DOFF + i*(CW+1) +: CW+1] + 1'b1) :
				data_s1[DOFF + i*(CW+1) +: CW+1];
		end
	end

	// Products n_i*d_i (lanes 0..2) and n_i*n_i (lanes 3..5)
	logic [6*CW-1:0]     m1_a;
	logic [6*(CW+1)-1:0] m1_b;
	logic                m1_v;
	logic [6*P1W-1:0]    m1_p;
	logic [SW1-1:0]      m1_side;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m1_a[i*CW +: CW]           = nm[i*CW +: CW];
			m1_a[(i+3)*CW +: CW]       = nm[i*CW +: CW];
			m1_b[i*(CW+1) +: CW+1]     = dm[i*(CW+1) +: CW+1];
			m1_b[(i+3)*(CW+1) +: CW+1] = {1'b0, nm[i*CW +: CW]};
		end
	end

	ppcf_mulpipe #(
		.LANES(6),
		.AW   (CW),
		.BW   (CW+1),
		.SW   (SW1)
	) u_mul_dot (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vld_i (v_s1),
		.a_i   (m1_a),
		.b_i   (m1_b),
		.side_i({data_s1[COFF +: OW], data_s1[WOFF +: DMW], nm, sn, sp}),
		.vld_o (m1_v),
		.p_o   (m1_p),
		.side_o(m1_side)
	);

	// Stage 2: sum the dot products, scale K*G by the weight
	logic [OW-1:0]          c1_cls;
	logic [DMW-1:0]         c1_w;
	logic [3*CW-1:0]        c1_nm;
	logic [2:0]             c1_sn;
	logic [2:0]             c1_sp;
	logic [DOTW-1:0]        dot;
	logic [N2W-1:0]         n2;
	logic [ppcf_pkg::KG_W+DMW-1:0] kgw_full;

	assign {c1_cls, c1_w, c1_nm, c1_sn, c1_sp} = m1_side;

	always_comb begin
		dot = '0;
		n2  = '0;
		for (int i = 0; i < 3; i++) begin
			if (c1_sp[i]) begin
				dot = dot - {1'b0, m1_p[i*P1W +: P1W]};
			end else begin
				dot = dot + {1'b0, m1_p[i*P1W +: P1W]};
			end
			n2 = n2 + m1_p[(i+3)*P1W +: N2W];
		end
	end

	assign kgw_full = (ppcf_pkg::KG_W+DMW)'(kg) * (ppcf_pkg::KG_W+DMW)'(c1_w);

	logic            v_s2;
	logic [OW-1:0]   cls_s2;
	logic [DOTM-1:0] dotm_s2;
	logic [KGWW-1:0] kgw_s2;
	logic [N2W-1:0]  n2_s2;
	logic [3*CW-1:0] nm_s2;
	logic [2:0]      sn_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= m1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if ((c1_cls == ppcf_pkg::OUT_APPLIED) && dot[DOTW-1]) begin
				cls_s2 <= ppcf_pkg::OUT_NOCONT;
			end else begin
				cls_s2 <= c1_cls;
			end
			dotm_s2 <= dot[DOTM-1:0];
			kgw_s2  <= kgw_full[KGWW-1:0];
			n2_s2   <= n2;
			nm_s2   <= c1_nm;
			sn_s2   <= c1_sn;
		end
	end

	// K*G*w times the dot product
	logic            m2_v;
	logic [KDW-1:0]  m2_p;
	logic [SW2-1:0]  m2_side;
	logic [OW-1:0]   c2_cls;
	logic [N2W-1:0]  c2_n2;
	logic [3*CW-1:0] c2_nm;
	logic [2:0]      c2_sn;

	ppcf_mulpipe #(
		.LANES(1),
		.AW   (KGWW),
		.BW   (DOTM),
		.SW   (SW2)
	) u_mul_kd (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vld_i (v_s2),
		.a_i   (kgw_s2),
		.b_i   (dotm_s2),
		.side_i({cls_s2, n2_s2, nm_s2, sn_s2}),
		.vld_o (m2_v),
		.p_o   (m2_p),
		.side_o(m2_side)
	);

	assign {c2_cls, c2_n2, c2_nm, c2_sn} = m2_side;

	// Times |n_i| for each axis
	logic            m3_v;
	logic [3*TW-1:0] m3_p;
	logic [SW3-1:0]  m3_side;
	logic [OW-1:0]   c3_cls;
	logic [N2W-1:0]  c3_n2;
	logic [2:0]      c3_sn;

	ppcf_mulpipe #(
		.LANES(3),
		.AW   (CW),
		.BW   (KDW),
		.SW   (SW3)
	) u_mul_axis (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vld_i (m2_v),
		.a_i   (c2_nm),
		.b_i   ({m2_p, m2_p, m2_p}),
		.side_i({c2_cls, c2_n2, c2_sn}),
		.vld_o (m3_v),
		.p_o   (m3_p),
		.side_o(m3_side)
	);

	assign {c3_cls, c3_n2, c3_sn} = m3_side;

	// Divide by |n|^2 * 2^24
	logic            dv_v;
	logic [3*FW-1:0] dv_q;
	logic [2:0]      dv_big;
	logic [SW4-1:0]  dv_side;
	logic [OW-1:0]   c4_cls;
	logic [2:0]      c4_sn;

	ppcf_divpipe #(
		.LANES(3),
		.NW   (TW),
		.DW   (DENW),
		.QB   (FW),
		.SW   (SW4)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vld_i (m3_v),
		.num_i (m3_p),
		.den_i ({c3_n2, {ppcf_pkg::DEN_SHIFT{1'b0}}}),
		.side_i({c3_cls, c3_sn}),
		.vld_o (dv_v),
		.q_o   (dv_q),
		.big_o (dv_big),
		.side_o(dv_side)
	);

	assign {c4_cls, c4_sn} = dv_side;

	// Sign, saturation and outcome
	logic [3*FW-1:0] fval;
	logic [2:0]      sat;
	logic [OW-1:0]   res_code;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (c4_sn[i]) begin
				sat[i]           = dv_big[i] || (dv_q[i*FW +: FW] > ppcf_pkg::F_MIN_MAG);
				fval[i*FW +: FW] = sat[i] ? ppcf_pkg::F_MIN_MAG : (~dv_q[i*FW +: FW] + 1'b1);
			end else begin
				sat[i]           = dv_big[i] || (dv_q[i*FW +: FW] > ppcf_pkg::F_MAX);
				fval[i*FW +: FW] = sat[i] ? ppcf_pkg::F_MAX : dv_q[i*FW +: FW];
			end
		end
		if (c4_cls != ppcf_pkg::OUT_APPLIED) begin
			res_code = c4_cls;
		end else if (sat != '0) begin
			res_code = ppcf_pkg::OUT_SAT;
		end else begin
			res_code = ppcf_pkg::OUT_APPLIED;
		end
	end

	// Result register
	logic          out_vld_q;
	logic [FW-1:0] fx_q;
	logic [FW-1:0] fy_q;
	logic [FW-1:0] fz_q;
	logic [OW-1:0] outcome_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			outcome_q <= res_code;
			if (c4_cls == ppcf_pkg::OUT_APPLIED) begin
				fx_q <= fval[0 +: FW];
				fy_q <= fval[FW +: FW];
				fz_q <= fval[2*FW +: FW];
			end else begin
				fx_q <= '0;
				fy_q <= '0;
				fz_q <= '0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign force_x   = fx_q;
	assign force_y   = fy_q;
	assign force_z   = fz_q;
	assign outcome   = outcome_q;

endmodule

`default_nettype wire

>>> hw/rtl/planar_penalty_contact_force.sv
// Top level of the planar penalty contact force block: registers, front, queue, back.
// The block takes one particle per clock cycle while in_stall is low and returns one result
// per particle, in order. The path from accept to result is dominated by the restoring
// divider that divides by |n|^2 and by the sliced wide multipliers. A stall on the result
// side freezes the back pipeline; a four-entry queue keeps the front taking items until
// it fills. A configuration write lands in its register; the group mask is used from that
// register directly, and K*G is registered once more from the stiffness and shear values.
`default_nettype none

module planar_penalty_contact_force #(
	parameter int COORD_WIDTH = ppcf_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [ppcf_pkg::GROUP_W-1:0]      particle_groups,
	input  wire logic                              has_mass,
	input  wire logic [COORD_WIDTH-1:0]            pos_x,
	input  wire logic [COORD_WIDTH-1:0]            pos_y,
	input  wire logic [COORD_WIDTH-1:0]            pos_z,
	input  wire logic [COORD_WIDTH-1:0]            surf_x,
	input  wire logic [COORD_WIDTH-1:0]            surf_y,
	input  wire logic [COORD_WIDTH-1:0]            surf_z,
	input  wire logic [COORD_WIDTH-1:0]            norm_x,
	input  wire logic [COORD_WIDTH-1:0]            norm_y,
	input  wire logic [COORD_WIDTH-1:0]            norm_z,
	input  wire logic [ppcf_pkg::DAMAGE_W-1:0]     damage_level,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [ppcf_pkg::FORCE_W-1:0]           force_x,
	output logic [ppcf_pkg::FORCE_W-1:0]           force_y,
	output logic [ppcf_pkg::FORCE_W-1:0]           force_z,
	output logic [ppcf_pkg::OUTCOME_W-1:0]         outcome,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ppcf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ppcf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int QW = 6*COORD_WIDTH + 3 + ppcf_pkg::DAMAGE_W + ppcf_pkg::OUTCOME_W;

	logic [ppcf_pkg::STIFF_W-1:0] stiff_q;
	logic [ppcf_pkg::SHEAR_W-1:0] shear_q;
	logic [ppcf_pkg::GROUP_W-1:0] group_q;
	logic [ppcf_pkg::KG_W-1:0]    kg_q;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= '0;
			shear_q <= '0;
			group_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ppcf_pkg::REG_STIFFNESS: begin
					stiff_q <= cfg_data[ppcf_pkg::STIFF_W-1:0];
				end
				ppcf_pkg::REG_SHEAR: begin
					shear_q <= cfg_data[ppcf_pkg::SHEAR_W-1:0];
				end
				ppcf_pkg::REG_GROUP: begin
					group_q <= cfg_data[ppcf_pkg::GROUP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// K*G, held ready for the back part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kg_q <= '0;
		end else begin
			kg_q <= ppcf_pkg::KG_W'(stiff_q) * ppcf_pkg::KG_W'(shear_q);
		end
	end

	logic          q_full;
	logic          q_push;
	logic [QW-1:0] q_wdata;
	logic          q_pop;
	logic          q_vld;
	logic [QW-1:0] q_rdata;

	ppcf_front #(
		.CW(COORD_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.particle_groups(particle_groups),
		.has_mass       (has_mass),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.surf_x         (surf_x),
		.surf_y         (surf_y),
		.surf_z         (surf_z),
		.norm_x         (norm_x),
		.norm_y         (norm_y),
		.norm_z         (norm_z),
		.damage_level   (damage_level),
		.group_select   (group_q),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_wdata)
	);

	ppcf_queue #(
		.W(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_vld),
		.pop_data (q_rdata)
	);

	ppcf_back #(
		.CW(COORD_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_vld    (q_vld),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.kg       (kg_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.force_x  (force_x),
		.force_y  (force_y),
		.force_z  (force_z),
		.outcome  (outcome)
	);

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the planar penalty contact force block.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = ppcf_pkg::COORD_WIDTH_DEF;
	localparam int RUN_LIMIT = 300000;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int PHASES = 5;
	localparam int DRAIN_CYCLES = 120;
	// index past the register list; the block must ignore it
	localparam logic [ppcf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [ppcf_pkg::GROUP_W-1:0]  groups;
		logic                          mass;
		logic signed [CW-1:0]          pos[3];
		logic signed [CW-1:0]          surf[3];
		logic signed [CW-1:0]          norm[3];
		logic [ppcf_pkg::DAMAGE_W-1:0] damage;
	} particle_t;

	typedef struct {
		logic [ppcf_pkg::FORCE_W-1:0] f[3];
		ppcf_pkg::outcome_t           outc;
	} force_res_t;

	typedef struct {
		particle_t  p;
		bit         typed;
		force_res_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [ppcf_pkg::GROUP_W-1:0] particle_groups;
	logic has_mass;
	logic [CW-1:0] pos_x, pos_y, pos_z, surf_x, surf_y, surf_z, norm_x, norm_y, norm_z;
	logic [ppcf_pkg::DAMAGE_W-1:0] damage_level;
	logic out_valid;
	logic out_stall;
	logic [ppcf_pkg::FORCE_W-1:0] force_x, force_y, force_z;
	logic [ppcf_pkg::OUTCOME_W-1:0] outcome;
	logic cfg_valid;
	logic cfg_ready;
	logic [ppcf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ppcf_pkg::CFG_DATA_W-1:0] cfg_data;

	// predictor copy of the registers
	logic [ppcf_pkg::STIFF_W-1:0] k_stiff;
	logic [ppcf_pkg::SHEAR_W-1:0] g_shear;
	logic [ppcf_pkg::GROUP_W-1:0] grp_mask;

	force_res_t pending_forces[$];
	int errors;
	int cycles;
	int burst_left;

	planar_penalty_contact_force #(.COORD_WIDTH(CW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.particle_groups(particle_groups), .has_mass(has_mass),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.surf_x(surf_x), .surf_y(surf_y), .surf_z(surf_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.damage_level(damage_level),
		.out_valid(out_valid), .out_stall(out_stall),
		.force_x(force_x), .force_y(force_y), .force_z(force_z), .outcome(outcome),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// exact penalty force: K*G*w*dot*n_i / (|n|^2 * 2^24), truncated, then clamped
	function automatic force_res_t contact_force(particle_t p);
		force_res_t r;
		logic signed [255:0] nv, sv, xv, dot, n2;
		logic [255:0] kg, mag, prod, quo, den;
		logic [63:0] kgw;
		logic [ppcf_pkg::DAMAGE_W-1:0] wt;
		r.f[0] = '0; r.f[1] = '0; r.f[2] = '0;
		r.outc = ppcf_pkg::OUT_APPLIED;
		if (!p.mass || (p.groups & grp_mask) == '0) begin
			r.outc = ppcf_pkg::OUT_SKIP;
			return r;
		end
		if (p.norm[0] == 0 && p.norm[1] == 0 && p.norm[2] == 0) begin
			r.outc = ppcf_pkg::OUT_ZERO;
			return r;
		end
		dot = 0;
		n2 = 0;
		for (int i = 0; i < 3; i++) begin
			nv = p.norm[i];
			sv = p.surf[i];
			xv = p.pos[i];
			dot = dot + nv * (sv - xv);
			n2 = n2 + nv * nv;
		end
		if (dot < 0) begin
			r.outc = ppcf_pkg::OUT_NOCONT;
			return r;
		end
		wt = (p.damage > ppcf_pkg::W_ONE) ? '0 : ppcf_pkg::W_ONE - p.damage;
		// product kept to 64 bits, as the block does
		kgw = 64'(k_stiff) * 64'(g_shear) * 64'(wt);
		kg = 256'(kgw) * 256'(dot);
		den = 256'(n2) << ppcf_pkg::DEN_SHIFT;
		for (int i = 0; i < 3; i++) begin
			nv = p.norm[i];
			mag = (nv < 0) ? 256'(-nv) : 256'(nv);
			prod = kg * mag;
			if (prod == 0) continue;
			quo = prod / den;
			if (nv >= 0) begin
				if (quo > 256'(ppcf_pkg::F_MAX)) begin
					r.f[i] = ppcf_pkg::F_MAX;
					r.outc = ppcf_pkg::OUT_SAT;
				end else r.f[i] = quo[ppcf_pkg::FORCE_W-1:0];
			end else begin
				if (quo > 256'(ppcf_pkg::F_MIN_MAG)) begin
					r.f[i] = ppcf_pkg::F_MIN_MAG;
					r.outc = ppcf_pkg::OUT_SAT;
				end else r.f[i] = -quo[ppcf_pkg::FORCE_W-1:0];
			end
		end
		return r;
	endfunction

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
			default: return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
		endcase
	endfunction

	function automatic particle_t rand_particle();
		particle_t p;
		p.groups = ($urandom_range(0, 4) == 0) ? $urandom : (grp_mask & $urandom) | $urandom;
		p.mass = ($urandom_range(0, 9) != 0);
		for (int i = 0; i < 3; i++) begin
			p.pos[i] = rand_coord();
			p.surf[i] = rand_coord();
			p.norm[i] = rand_coord();
		end
		if ($urandom_range(0, 24) == 0) begin
			p.norm[0] = '0; p.norm[1] = '0; p.norm[2] = '0;
		end
		case ($urandom_range(0, 7))
			0: p.damage = $urandom;
			1: p.damage = ppcf_pkg::W_ONE;
			default: p.damage = $urandom_range(0, 32'h1_0000);
		endcase
		return p;
	endfunction

	function automatic particle_t plain_particle(logic signed [CW-1:0] sz, logic signed [CW-1:0] pz,
			logic signed [CW-1:0] nz);
		particle_t p;
		p.groups = '1;
		p.mass = 1'b1;
		for (int i = 0; i < 3; i++) begin
			p.pos[i] = '0; p.surf[i] = '0; p.norm[i] = '0;
		end
		p.surf[2] = sz;
		p.pos[2] = pz;
		p.norm[2] = nz;
		p.damage = '0;
		return p;
	endfunction

	function automatic force_res_t zero_res(ppcf_pkg::outcome_t o);
		force_res_t r;
		r.f[0] = '0; r.f[1] = '0; r.f[2] = '0;
		r.outc = o;
		return r;
	endfunction

	// one item: hold until accepted, then record the expected forces
	task automatic send_particle(particle_t p, bit typed, force_res_t typed_res);
		in_valid <= 1'b1;
		particle_groups <= p.groups;
		has_mass <= p.mass;
		pos_x <= p.pos[0]; pos_y <= p.pos[1]; pos_z <= p.pos[2];
		surf_x <= p.surf[0]; surf_y <= p.surf[1]; surf_z <= p.surf[2];
		norm_x <= p.norm[0]; norm_y <= p.norm[1]; norm_z <= p.norm[2];
		damage_level <= p.damage;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_forces.push_back(typed ? typed_res : contact_force(p));
		// bursty sender
		if (burst_left > 0) burst_left--;
		else begin
			burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [ppcf_pkg::CFG_IDX_W-1:0] idx,
			logic [ppcf_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			ppcf_pkg::REG_STIFFNESS: k_stiff = val[ppcf_pkg::STIFF_W-1:0];
			ppcf_pkg::REG_SHEAR:     g_shear = val;
			ppcf_pkg::REG_GROUP:     grp_mask = val;
			default:                 ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_forces.size() != 0) @(posedge clk);
	endtask

	// result side stalls in modes of random length
	initial begin
		int mode;
		int span;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(10, 120);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// compare each delivered item with the oldest expectation
	always @(posedge clk) begin
		force_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_forces.size() == 0) begin
				$display("%0t: unexpected item force=(%h %h %h) outcome=%0d",
					$time, force_x, force_y, force_z, outcome);
				errors++;
			end else begin
				e = pending_forces.pop_front();
				if (force_x !== e.f[0]) begin
					$display("%0t: force_x expected %h actual %h", $time, e.f[0], force_x);
					errors++;
				end
				if (force_y !== e.f[1]) begin
					$display("%0t: force_y expected %h actual %h", $time, e.f[1], force_y);
					errors++;
				end
				if (force_z !== e.f[2]) begin
					$display("%0t: force_z expected %h actual %h", $time, e.f[2], force_z);
					errors++;
				end
				if (outcome !== e.outc) begin
					$display("%0t: outcome expected %0d actual %0d", $time, e.outc, outcome);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("planar_penalty_contact_force test failed");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		particle_t p;
		force_res_t none;
		errors = 0;
		cycles = 0;
		burst_left = 0;
		k_stiff = '0; g_shear = '0; grp_mask = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		particle_groups = '0; has_mass = 1'b0;
		pos_x = '0; pos_y = '0; pos_z = '0;
		surf_x = '0; surf_y = '0; surf_z = '0;
		norm_x = '0; norm_y = '0; norm_z = '0;
		damage_level = '0;
		cfg_valid = 1'b0; cfg_index = ppcf_pkg::REG_STIFFNESS; cfg_data = '0;
		none = zero_res(ppcf_pkg::OUT_SKIP);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the group mask is clear, so every particle is skipped
		p = plain_particle(32'sh0001_0000, '0, 32'sh0001_0000);
		send_particle(p, 1'b1, zero_res(ppcf_pkg::OUT_SKIP));
		p = rand_particle();
		send_particle(p, 1'b1, zero_res(ppcf_pkg::OUT_SKIP));
		wait_idle();

		write_reg(ppcf_pkg::REG_STIFFNESS, 32'h0000_FFFF);
		write_reg(ppcf_pkg::REG_SHEAR, 32'hFFFF_FFFF);
		write_reg(ppcf_pkg::REG_GROUP, 32'h0000_00FF);
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);

		// directed table: typed rows carry their result, the rest go to the predictor
		p = plain_particle(32'sh0001_0000, '0, 32'sh0001_0000);
		p.mass = 1'b0;
		row.p = p; row.typed = 1; row.res = zero_res(ppcf_pkg::OUT_SKIP); rows.push_back(row);
		p.mass = 1'b1; p.groups = 32'hFFFF_FF00;
		row.p = p; row.typed = 1; row.res = zero_res(ppcf_pkg::OUT_SKIP); rows.push_back(row);
		p = plain_particle(32'sh0001_0000, '0, '0);
		row.p = p; row.typed = 1; row.res = zero_res(ppcf_pkg::OUT_ZERO); rows.push_back(row);
		p = plain_particle('0, 32'sh0001_0000, 32'sh0001_0000);
		row.p = p; row.typed = 1; row.res = zero_res(ppcf_pkg::OUT_NOCONT); rows.push_back(row);
		// zero penetration
		p = plain_particle(32'sh0003_0000, 32'sh0003_0000, 32'sh0001_0000);
		row.p = p; row.typed = 1; row.res = zero_res(ppcf_pkg::OUT_APPLIED); rows.push_back(row);
		// fully damaged and over-damaged
		p = plain_particle(32'sh0001_0000, '0, 32'sh0001_0000);
		p.damage = ppcf_pkg::W_ONE;
		row.p = p; row.typed = 1; row.res = zero_res(ppcf_pkg::OUT_APPLIED); rows.push_back(row);
		p.damage = '1;
		row.p = p; row.typed = 1; row.res = zero_res(ppcf_pkg::OUT_APPLIED); rows.push_back(row);
		row.typed = 0; row.res = none;
		p.damage = '0;
		row.p = p; rows.push_back(row);
		p.damage = 17'hFFFF;
		row.p = p; rows.push_back(row);
		p = plain_particle(32'sh0000_0001, '0, {1'b0, {(CW-1){1'b1}}});
		p.damage = 17'h1_0000 - 1;
		row.p = p; rows.push_back(row);
		// coordinate extremes
		for (int i = 0; i < 3; i++) begin
			p.pos[i] = {1'b1, {(CW-1){1'b0}}};
			p.surf[i] = {1'b0, {(CW-1){1'b1}}};
			p.norm[i] = {1'b1, {(CW-1){1'b0}}};
		end
		p.damage = '0;
		row.p = p; rows.push_back(row);
		for (int i = 0; i < 3; i++) begin
			p.norm[i] = {1'b0, {(CW-1){1'b1}}};
			p.surf[i] = {1'b1, {(CW-1){1'b0}}};
			p.pos[i] = {1'b0, {(CW-1){1'b1}}};
		end
		row.p = p; rows.push_back(row);
		p.norm[0] = 32'sh0001_0000; p.norm[1] = -32'sh0002_0000; p.norm[2] = 32'sh0000_8000;
		p.pos[0] = '0; p.pos[1] = 32'sh0000_4000; p.pos[2] = -32'sh0001_0000;
		p.surf[0] = 32'sh0000_1000; p.surf[1] = -32'sh0001_0000; p.surf[2] = '0;
		p.groups = 32'h0000_0001;
		row.p = p; rows.push_back(row);
		p.groups = 32'h8000_0080;
		row.p = p; rows.push_back(row);
		foreach (rows[i]) send_particle(rows[i].p, rows[i].typed, rows[i].res);
		wait_idle();

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(ppcf_pkg::REG_STIFFNESS, 32'd1);
					write_reg(ppcf_pkg::REG_SHEAR, 32'h0000_0100);
					write_reg(ppcf_pkg::REG_GROUP, 32'hFFFF_FFFF);
				end
				1: begin
					write_reg(ppcf_pkg::REG_STIFFNESS, 32'd0);
					write_reg(ppcf_pkg::REG_SHEAR, 32'd0);
					write_reg(ppcf_pkg::REG_GROUP, $urandom);
				end
				2: begin
					write_reg(ppcf_pkg::REG_STIFFNESS, 32'h0000_FFFF);
					write_reg(ppcf_pkg::REG_SHEAR, 32'hFFFF_FFFF);
					write_reg(ppcf_pkg::REG_GROUP, $urandom);
				end
				default: begin
					write_reg(ppcf_pkg::REG_STIFFNESS, $urandom_range(1, 200));
					write_reg(ppcf_pkg::REG_SHEAR, $urandom_range(1, 32'h0010_0000));
					write_reg(ppcf_pkg::REG_GROUP, $urandom | $urandom);
				end
			endcase
			repeat (ITEMS_PER_PHASE) send_particle(rand_particle(), 1'b0, none);
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) $display("planar_penalty_contact_force test passed");
		else $display("planar_penalty_contact_force test failed");
		$finish;
	end
endmodule

`default_nettype wire

>>> files.f
hw/rtl/ppcf_pkg.sv
hw/rtl/ppcf_mulpipe.sv
hw/rtl/ppcf_divpipe.sv
hw/rtl/ppcf_queue.sv
hw/rtl/ppcf_front.sv
hw/rtl/ppcf_back.sv
hw/rtl/planar_penalty_contact_force.sv
tb/tb.sv
